>>> hw/rtl/cst_pkg.sv
// shared types, field widths and codes for the counting semaphore table
`timescale 1ns / 1ps
package cst_pkg;

	localparam int SEM_SLOTS_DEF  = 16;
	localparam int WAIT_NODES_DEF = 32;

	localparam int MODE_W   = 3;
	localparam int ID_W     = 32;
	localparam int COUNT_W  = 16;
	localparam int TICK_W   = 32;
	localparam int TASK_W   = 6;
	localparam int STATUS_W = 3;
	localparam int IDX_MAX_W = 8;

	localparam int IN_W  = 144;
	localparam int OUT_W = 96;

	localparam logic [MODE_W-1:0] MODE_CREATE = 3'd0;
	localparam logic [MODE_W-1:0] MODE_DELETE = 3'd1;
	localparam logic [MODE_W-1:0] MODE_TAKE   = 3'd2;
	localparam logic [MODE_W-1:0] MODE_GIVE   = 3'd3;
	localparam logic [MODE_W-1:0] MODE_QUERY  = 3'd4;

	localparam logic [STATUS_W-1:0] ST_OK          = 3'd0;
	localparam logic [STATUS_W-1:0] ST_UNAVAILABLE = 3'd1;
	localparam logic [STATUS_W-1:0] ST_INVALID     = 3'd2;
	localparam logic [STATUS_W-1:0] ST_NO_SLOT     = 3'd3;
	localparam logic [STATUS_W-1:0] ST_ISR         = 3'd4;
	localparam logic [STATUS_W-1:0] ST_TIMEOUT     = 3'd5;
	localparam logic [STATUS_W-1:0] ST_FULL        = 3'd6;
	localparam logic [STATUS_W-1:0] ST_BLOCKED     = 3'd7;

	typedef enum logic [2:0] {
		S_IDLE,
		S_LOOKUP,
		S_SLOT,
		S_NODE,
		S_LINK,
		S_OUT
	} state_t;

	typedef struct packed {
		logic [MODE_W-1:0]  mode;
		logic [ID_W-1:0]    sem_id;
		logic [COUNT_W-1:0] init_cnt;
		logic [COUNT_W-1:0] limit_cnt;
		logic [TICK_W-1:0]  wait_ticks;
		logic [TICK_W-1:0]  now_tick;
		logic [TASK_W-1:0]  task_id;
		logic               in_isr;
	} req_t;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [ID_W-1:0]     new_id;
		logic [COUNT_W-1:0]  count_now;
		logic                woken_valid;
		logic [TASK_W-1:0]   woken_task;
		logic [TICK_W-1:0]   wake_deadline;
	} res_t;

	typedef struct packed {
		logic                 found;
		logic [IDX_MAX_W-1:0] slot;
		logic                 free_found;
		logic [IDX_MAX_W-1:0] free_slot;
	} lookup_t;

	typedef struct packed {
		logic                 we;
		logic [IDX_MAX_W-1:0] slot;
		logic [ID_W-1:0]      value;
	} ident_wr_t;

endpackage

>>> hw/rtl/counting_semaphore_table.sv
// counting semaphore table top level: request sequencer, slot and wait node memories
// create and a request refused at lookup go from lookup straight to the output state; a found
// query, delete, take or give reads its slot, then a give that wakes a task walks one wait node,
// a delete walks every waiting node in turn, a take joining a non-empty queue writes the tail
// link, and all then reach the output state; only one request is in flight at a time, and a
// result still held in the output register stalls the acceptance of the next request
// reset clears identifiers, free node map, counter and control; ram contents need no clearing
`timescale 1ns / 1ps
module counting_semaphore_table #(
	parameter int SEM_SLOTS  = cst_pkg::SEM_SLOTS_DEF,
	parameter int WAIT_NODES = cst_pkg::WAIT_NODES_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      s_tvalid,
	output logic                      s_tready,
	// mode, sem_id, init_cnt, limit_cnt, wait_ticks, now_tick, task_id, in_isr
	input  logic [cst_pkg::IN_W-1:0]  s_tdata,
	output logic                      m_tvalid,
	input  logic                      m_tready,
	// status, new_id, count_now, woken_valid, woken_task, wake_deadline
	output logic [cst_pkg::OUT_W-1:0] m_tdata,
	input  logic                      cfg_we,
	input  logic                      cfg_wdata
);
	localparam int SW = SEM_SLOTS > 1 ? $clog2(SEM_SLOTS) : 1;
	localparam int NW = WAIT_NODES > 1 ? $clog2(WAIT_NODES) : 1;
	localparam int CW = cst_pkg::COUNT_W;
	localparam int REC_W = 2 * CW + 2 * NW + 1;

	cst_pkg::state_t  state_q, state_d;
	cst_pkg::req_t    req_q;
	cst_pkg::res_t    res_q, res_d;
	cst_pkg::lookup_t lk;
	cst_pkg::ident_wr_t ident_wr;

	logic                     kready_q;
	logic [cst_pkg::ID_W-1:0] ctr_q, ctr_inc, ctr_next;
	logic                     ctr_load;
	logic [WAIT_NODES-1:0]    free_q;
	logic                     free_any;
	logic [NW-1:0]            free_first;
	logic                     free_set, free_clr;
	logic [NW-1:0]            free_idx;

	logic [SW-1:0]   slot_q;
	logic [NW-1:0]   node_ptr_q, node_ptr_d;
	logic [NW-1:0]   tail_q, tail_d;
	logic [NW-1:0]   newn_q, newn_d;
	logic [REC_W-1:0] rec_q, rec_d;

	logic             slot_we;
	logic [SW-1:0]    slot_waddr;
	logic [REC_W-1:0] slot_wdata, slot_rdata;
	logic             link_we;
	logic [NW-1:0]    link_waddr, node_raddr;
	logic [NW:0]      link_wdata, link_rdata;
	logic             task_we;
	logic [cst_pkg::TASK_W-1:0] task_rdata;

	logic go_slot, go_node, go_link, node_more;

	logic [CW-1:0] r_count, r_limit;
	logic [NW-1:0] r_head, r_tail;
	logic          r_qv;
	logic [CW-1:0] q_count;
	logic [NW-1:0] q_head, q_tail;

	logic [cst_pkg::OUT_W-1:0] m_tdata_q;
	logic                      m_tvalid_q;

	assign s_tready = (state_q == cst_pkg::S_IDLE);
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	assign r_count = slot_rdata[CW-1:0];
	assign r_limit = slot_rdata[2*CW-1:CW];
	assign r_head  = slot_rdata[2*CW+NW-1:2*CW];
	assign r_tail  = slot_rdata[2*CW+2*NW-1:2*CW+NW];
	assign r_qv    = slot_rdata[REC_W-1];
	assign q_count = rec_q[CW-1:0];
	assign q_head  = rec_q[2*CW+NW-1:2*CW];
	assign q_tail  = rec_q[2*CW+2*NW-1:2*CW+NW];

	assign ctr_inc  = ctr_q + 1'b1;
	assign ctr_next = (ctr_inc == '0) ? cst_pkg::ID_W'(1) : ctr_inc;

	always_comb begin
		free_any   = 1'b0;
		free_first = '0;
		for (int i = WAIT_NODES - 1; i >= 0; i--) begin
			if (free_q[i]) begin
				free_any   = 1'b1;
				free_first = NW'(i);
			end
		end
	end

	cst_lookup #(.SEM_SLOTS(SEM_SLOTS)) u_lookup (
		.clk    (clk),
		.arst_n (arst_n),
		.sem_id (req_q.sem_id),
		.wr     (ident_wr),
		.lk     (lk)
	);

	cst_ram #(.WIDTH(REC_W), .DEPTH(SEM_SLOTS)) u_slot_ram (
		.clk   (clk),
		.we    (slot_we),
		.waddr (slot_waddr),
		.wdata (slot_wdata),
		.raddr (lk.slot[SW-1:0]),
		.rdata (slot_rdata)
	);

	cst_ram #(.WIDTH(NW + 1), .DEPTH(WAIT_NODES)) u_link_ram (
		.clk   (clk),
		.we    (link_we),
		.waddr (link_waddr),
		.wdata (link_wdata),
		.raddr (node_raddr),
		.rdata (link_rdata)
	);

	cst_ram #(.WIDTH(cst_pkg::TASK_W), .DEPTH(WAIT_NODES)) u_task_ram (
		.clk   (clk),
		.we    (task_we),
		.waddr (free_first),
		.wdata (req_q.task_id),
		.raddr (node_raddr),
		.rdata (task_rdata)
	);

	// request datapath and memory control
	always_comb begin
		res_d      = res_q;
		ident_wr   = '0;
		ctr_load   = 1'b0;
		free_set   = 1'b0;
		free_clr   = 1'b0;
		free_idx   = node_ptr_q;
		slot_we    = 1'b0;
		slot_waddr = slot_q;
		slot_wdata = '0;
		link_we    = 1'b0;
		link_waddr = free_first;
		link_wdata = '0;
		task_we    = 1'b0;
		node_raddr = node_ptr_q;
		node_ptr_d = node_ptr_q;
		tail_d     = tail_q;
		newn_d     = newn_q;
		rec_d      = rec_q;
		go_slot    = 1'b0;
		go_node    = 1'b0;
		go_link    = 1'b0;
		node_more  = 1'b0;
		case (state_q)
			cst_pkg::S_LOOKUP: begin
				res_d = '0;
				case (req_q.mode)
					cst_pkg::MODE_CREATE: begin
						if (!kready_q) begin
							res_d.status = cst_pkg::ST_UNAVAILABLE;
						end else if (req_q.init_cnt > req_q.limit_cnt) begin
							res_d.status = cst_pkg::ST_INVALID;
						end else if (!lk.free_found) begin
							res_d.status = cst_pkg::ST_NO_SLOT;
						end else begin
							ident_wr.we    = 1'b1;
							ident_wr.slot  = lk.free_slot;
							ident_wr.value = ctr_next;
							ctr_load       = 1'b1;
							slot_we        = 1'b1;
							slot_waddr     = lk.free_slot[SW-1:0];
							slot_wdata     = {1'b0, {(2*NW){1'b0}}, req_q.limit_cnt,
								req_q.init_cnt};
							res_d.new_id    = ctr_next;
							res_d.count_now = req_q.init_cnt;
						end
					end
					cst_pkg::MODE_DELETE, cst_pkg::MODE_GIVE, cst_pkg::MODE_QUERY: begin
						if (!lk.found) begin
							res_d.status = cst_pkg::ST_UNAVAILABLE;
						end else begin
							go_slot = 1'b1;
						end
					end
					cst_pkg::MODE_TAKE: begin
						if (req_q.in_isr) begin
							res_d.status = cst_pkg::ST_ISR;
						end else if (!lk.found) begin
							res_d.status = cst_pkg::ST_UNAVAILABLE;
						end else begin
							go_slot = 1'b1;
						end
					end
					default: begin
						res_d.status = cst_pkg::ST_INVALID;
					end
				endcase
			end
			cst_pkg::S_SLOT: begin
				case (req_q.mode)
					cst_pkg::MODE_QUERY: begin
						res_d.count_now = r_count;
					end
					cst_pkg::MODE_DELETE: begin
						ident_wr.we   = 1'b1;
						ident_wr.slot = cst_pkg::IDX_MAX_W'(slot_q);
						slot_we       = 1'b1;
						if (r_qv) begin
							node_raddr = r_head;
							node_ptr_d = r_head;
							go_node    = 1'b1;
						end
					end
					cst_pkg::MODE_TAKE: begin
						if (r_count != '0) begin
							slot_we         = 1'b1;
							slot_wdata      = {slot_rdata[REC_W-1:CW], r_count - 1'b1};
							res_d.count_now = r_count - 1'b1;
						end else if (req_q.wait_ticks == '0) begin
							res_d.status = cst_pkg::ST_TIMEOUT;
						end else if (req_q.task_id == '0) begin
							res_d.status = cst_pkg::ST_UNAVAILABLE;
						end else begin
							res_d.status        = cst_pkg::ST_BLOCKED;
							res_d.wake_deadline = req_q.now_tick + req_q.wait_ticks;
							if (free_any) begin
								free_clr   = 1'b1;
								free_idx   = free_first;
								task_we    = 1'b1;
								link_we    = 1'b1;
								slot_we    = 1'b1;
								slot_wdata = {1'b1, free_first, r_qv ? r_head : free_first,
									r_limit, r_count};
								tail_d     = r_tail;
								newn_d     = free_first;
								go_link    = r_qv;
							end
						end
					end
					cst_pkg::MODE_GIVE: begin
						if (r_count >= r_limit) begin
							res_d.status    = cst_pkg::ST_FULL;
							res_d.count_now = r_count;
						end else begin
							res_d.count_now = r_count + 1'b1;
							rec_d = {slot_rdata[REC_W-1:CW], r_count + 1'b1};
							if (r_qv) begin
								node_raddr = r_head;
								node_ptr_d = r_head;
								go_node    = 1'b1;
							end else begin
								slot_we    = 1'b1;
								slot_wdata = {slot_rdata[REC_W-1:CW], r_count + 1'b1};
							end
						end
					end
					default: begin
						res_d.status = cst_pkg::ST_INVALID;
					end
				endcase
			end
			cst_pkg::S_NODE: begin
				free_set = 1'b1;
				if (req_q.mode == cst_pkg::MODE_GIVE) begin
					res_d.woken_valid = 1'b1;
					res_d.woken_task  = task_rdata;
					slot_we           = 1'b1;
					if (link_rdata[NW]) begin
						slot_wdata = {1'b1, q_tail, link_rdata[NW-1:0], rec_q[2*CW-1:CW],
							q_count};
					end else begin
						slot_wdata = {1'b0, q_tail, q_head, rec_q[2*CW-1:CW], q_count};
					end
				end else if (link_rdata[NW]) begin
					node_raddr = link_rdata[NW-1:0];
					node_ptr_d = link_rdata[NW-1:0];
					node_more  = 1'b1;
				end
			end
			cst_pkg::S_LINK: begin
				link_we    = 1'b1;
				link_waddr = tail_q;
				link_wdata = {1'b1, newn_q};
			end
			default: begin
			end
		endcase
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			cst_pkg::S_IDLE: begin
				if (s_tvalid) begin
					state_d = cst_pkg::S_LOOKUP;
				end
			end
			cst_pkg::S_LOOKUP: begin
				state_d = go_slot ? cst_pkg::S_SLOT : cst_pkg::S_OUT;
			end
			cst_pkg::S_SLOT: begin
				if (go_node) begin
					state_d = cst_pkg::S_NODE;
				end else if (go_link) begin
					state_d = cst_pkg::S_LINK;
				end else begin
					state_d = cst_pkg::S_OUT;
				end
			end
			cst_pkg::S_NODE: begin
				state_d = node_more ? cst_pkg::S_NODE : cst_pkg::S_OUT;
			end
			cst_pkg::S_LINK: begin
				state_d = cst_pkg::S_OUT;
			end
			cst_pkg::S_OUT: begin
				if (!m_tvalid_q || m_tready) begin
					state_d = cst_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = cst_pkg::S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= cst_pkg::S_IDLE;
			kready_q   <= 1'b0;
			ctr_q      <= '0;
			free_q     <= '1;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				kready_q <= cfg_wdata;
			end
			if (ctr_load) begin
				ctr_q <= ctr_next;
			end
			if (free_set) begin
				free_q[free_idx] <= 1'b1;
			end else if (free_clr) begin
				free_q[free_idx] <= 1'b0;
			end
			if (state_q == cst_pkg::S_OUT && (!m_tvalid_q || m_tready)) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			req_q.mode       <= s_tdata[2:0];
			req_q.sem_id     <= s_tdata[34:3];
			req_q.init_cnt   <= s_tdata[50:35];
			req_q.limit_cnt  <= s_tdata[66:51];
			req_q.wait_ticks <= s_tdata[98:67];
			req_q.now_tick   <= s_tdata[130:99];
			req_q.task_id    <= s_tdata[136:131];
			req_q.in_isr     <= s_tdata[137];
		end
		if (state_q == cst_pkg::S_LOOKUP) begin
			slot_q <= lk.slot[SW-1:0];
		end
		res_q      <= res_d;
		rec_q      <= rec_d;
		node_ptr_q <= node_ptr_d;
		tail_q     <= tail_d;
		newn_q     <= newn_d;
		if (state_q == cst_pkg::S_OUT && (!m_tvalid_q || m_tready)) begin
			m_tdata_q <= {6'd0, res_q.wake_deadline, res_q.woken_task, res_q.woken_valid,
				res_q.count_now, res_q.new_id, res_q.status};
		end
	end

	a_node_mode: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == cst_pkg::S_NODE |->
			req_q.mode == cst_pkg::MODE_GIVE || req_q.mode == cst_pkg::MODE_DELETE)
		else $error("node walk outside give or delete");

	a_link_after_slot: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == cst_pkg::S_LINK |-> $past(state_q) == cst_pkg::S_SLOT)
		else $error("tail link write out of order");

	a_node_in_use: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == cst_pkg::S_NODE |-> !free_q[node_ptr_q])
		else $error("walked node already free");

	a_accept_lookup: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> state_q == cst_pkg::S_LOOKUP)
		else $error("request not looked up");

	a_alloc_free: assert property (@(posedge clk) disable iff (!arst_n)
		free_clr |-> free_q[free_idx] && !free_set)
		else $error("allocated node not free");
endmodule

>>> hw/rtl/cst_ram.sv
// generic single write port ram with registered read
`timescale 1ns / 1ps
module cst_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

>>> hw/rtl/cst_lookup.sv
// identifier registers with match and free slot search
`timescale 1ns / 1ps
module cst_lookup #(
	parameter int SEM_SLOTS = cst_pkg::SEM_SLOTS_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic [cst_pkg::ID_W-1:0] sem_id,
	input  cst_pkg::ident_wr_t      wr,
	output cst_pkg::lookup_t        lk
);
	localparam int SW = SEM_SLOTS > 1 ? $clog2(SEM_SLOTS) : 1;

	logic [cst_pkg::ID_W-1:0] ident_q [SEM_SLOTS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < SEM_SLOTS; i++) begin
				ident_q[i] <= '0;
			end
		end else if (wr.we) begin
			ident_q[wr.slot[SW-1:0]] <= wr.value;
		end
	end

	always_comb begin
		lk = '0;
		for (int i = SEM_SLOTS - 1; i >= 0; i--) begin
			if (sem_id != '0 && ident_q[i] == sem_id) begin
				lk.found = 1'b1;
				lk.slot  = cst_pkg::IDX_MAX_W'(i);
			end
			if (ident_q[i] == '0) begin
				lk.free_found = 1'b1;
				lk.free_slot  = cst_pkg::IDX_MAX_W'(i);
			end
		end
	end
endmodule
